### hw/rtl/ptn3_pkg.sv
// ----------------------------------------------------------------------------
// ptn3_pkg: shared types and constants for the place table
// Widths, opcodes, status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package ptn3_pkg;

   localparam int TableDepth   = 64;
   localparam int IdxBits      = $clog2(TableDepth);
   localparam int NearestCount = 3;
   localparam int CoordBits    = 16;
   localparam int DiffBits     = CoordBits + 1;
   localparam int SqBits       = 2 * DiffBits + 1;
   localparam int RootBits     = (SqBits + 1) / 2;
   localparam int RankBits     = $clog2(NearestCount + 1);

   typedef enum logic [2:0] {
      OP_CLEAR  = 3'd0,
      OP_ADD    = 3'd1,
      OP_REMOVE = 3'd2,
      OP_MOVE   = 3'd3,
      OP_READ   = 3'd4,
      OP_QUERY  = 3'd5
   } opcode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_PRESENT  = 3'd1,
      ST_ABSENT   = 3'd2,
      ST_FULL     = 3'd3,
      ST_NO_MATCH = 3'd4
   } status_type;

   localparam logic [2:0] AnyType = 3'd7;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_FIN,
      S_Q_RD,
      S_Q_CHK,
      S_SQ,
      S_ROOT,
      S_INS,
      S_EMIT,
      S_EMIT_ID,
      S_RSP
   } state_type;

   typedef struct packed {
      logic [2:0]            status;
      logic [31:0]           result_id;
      logic signed [15:0]    result_x;
      logic signed [15:0]    result_y;
      logic                  last_result;
   } rsp_type;

   typedef struct packed {
      logic [2:0]            opcode;
      logic [31:0]           place_id;
      logic signed [15:0]    coord_x;
      logic signed [15:0]    coord_y;
      logic [2:0]            place_type;
   } req_type;

endpackage

### hw/rtl/ptn3_if.sv
// ----------------------------------------------------------------------------
// ptn3_req_if / ptn3_rsp_if: valid/ready channels
// One interface per channel direction payload.
// ----------------------------------------------------------------------------
interface ptn3_req_if;
   logic               valid;
   logic               ready;
   ptn3_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ptn3_rsp_if;
   logic               valid;
   logic               ready;
   ptn3_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### hw/rtl/ptn3_isqrt.sv
// ----------------------------------------------------------------------------
// ptn3_isqrt: bit-serial integer square root
// Restoring square root, two radicand bits per cycle; floor result.
// ----------------------------------------------------------------------------
module ptn3_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [ptn3_pkg::SqBits-1:0]   radicand,
   output logic                          done,
   output logic [ptn3_pkg::RootBits-1:0] root
);
   import ptn3_pkg::*;

   localparam int RadBits = 2 * RootBits;
   localparam int CntBits = $clog2(RootBits + 1);

   logic [RadBits-1:0]  rad_ff, rad_in;
   logic [RootBits+1:0] rem_ff, rem_in;
   logic [RootBits-1:0] q_ff, q_in;
   logic [CntBits-1:0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [RootBits+1:0] trial, shifted;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff[RootBits-1:0], rad_ff[RadBits-1 -: 2]};
      trial   = {q_ff, 2'b01};
      if (start) begin
         rad_in  = RadBits'(radicand);
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CntBits'(RootBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RadBits-3:0], 2'b00};
         if (shifted >= trial) begin
            rem_in = shifted - trial;
            q_in   = {q_ff[RootBits-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[RootBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntBits'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (reset) busy_ff <= 1'b0;
      else       busy_ff <= busy_in;
   end

   assign done = busy_ff && (cnt_ff == CntBits'(1));
   assign root = q_in;

   a_cnt_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0) else $error("isqrt count zero while busy");
   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done && !start |=> !busy_ff) else $error("isqrt busy after done");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("isqrt did not start");
endmodule

### hw/rtl/place_table_nearest_three.sv
// ----------------------------------------------------------------------------
// place_table_nearest_three: place table with nearest-three search
// Table of places with add/remove/move/read and a ranked nearest query.
// ----------------------------------------------------------------------------
// Usage: one request transaction on req carries an opcode, id, point and
// type. The block answers on rsp with one transaction, or for a query with
// up to three, the final one marked by last_result. Opcodes six and seven
// give no response.
// Operation: a lookup walks the 64-entry table through the single memory read
// port, one slot at a time, a read state then a check state. A query visits
// each slot the same way and, for each match, squares with one shared
// multiplier and runs the bit-serial root before a ranking insert.
// One request is worked at a time; req ready is low meanwhile, and also
// while an earlier response still waits in the output register.
// Reset empties the table at once (valid bits in flip-flops).
// If the receiver stalls, the response register holds and the sequencer
// waits; no transaction is lost.
// ----------------------------------------------------------------------------
module place_table_nearest_three (
   input  logic clock,
   input  logic reset,
   ptn3_req_if.sink   req,
   ptn3_rsp_if.source rsp
);
   import ptn3_pkg::*;

   state_type state_ff, state_in;
   req_type   cur_ff, cur_in;

   logic [TableDepth-1:0] valid_ff, valid_in;
   logic [31:0]            mem_id   [TableDepth];
   logic [CoordBits-1:0]   mem_x    [TableDepth];
   logic [CoordBits-1:0]   mem_y    [TableDepth];
   logic [2:0]             mem_type [TableDepth];

   logic [IdxBits:0]     idx_ff, idx_in;
   logic [31:0]          rd_id_ff;
   logic [CoordBits-1:0] rd_x_ff, rd_y_ff;
   logic [2:0]           rd_type_ff;
   logic                 found_ff, found_in;
   logic [IdxBits-1:0]   hit_ff, hit_in;
   logic                 free_ok_ff, free_ok_in;
   logic [IdxBits-1:0]   free_ff, free_in;

   logic                 we;
   logic [IdxBits-1:0]   wa;
   logic                 wr_id;
   logic [31:0]          wd_id;
   logic [CoordBits-1:0] wd_x, wd_y;
   logic [2:0]           wd_type;

   // squaring unit
   logic                 sq_sel_ff, sq_sel_in;
   logic [DiffBits-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic [SqBits-1:0]    sq_ff, sq_in;
   logic [DiffBits-1:0]  mul_op;
   logic [2*DiffBits-1:0] mul_p;

   logic                 rt_start;
   logic                 rt_done;
   logic [RootBits-1:0]  rt_root;
   logic [RootBits-1:0]  dist_ff, dist_in;

   // ranked list
   logic [RootBits-1:0]  bd_ff [NearestCount];
   logic [CoordBits-1:0] by_ff [NearestCount];
   logic [31:0]          bi_ff [NearestCount];
   logic [RootBits-1:0]  bd_in [NearestCount];
   logic [CoordBits-1:0] by_in [NearestCount];
   logic [31:0]          bi_in [NearestCount];
   logic [RankBits-1:0]  n_ff, n_in;
   logic [RankBits-1:0]  k_ff, k_in;
   logic [NearestCount-1:0] beats;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_v_ff, rsp_v_in;

   ptn3_isqrt u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (rt_start),
      .radicand (sq_ff),
      .done     (rt_done),
      .root     (rt_root)
   );

   always_ff @(posedge clock) begin
      if (we) begin
         if (wr_id) begin
            mem_id[wa]   <= wd_id;
            mem_type[wa] <= wd_type;
         end
         mem_x[wa] <= wd_x;
         mem_y[wa] <= wd_y;
      end
      rd_id_ff   <= mem_id[idx_ff[IdxBits-1:0]];
      rd_x_ff    <= mem_x[idx_ff[IdxBits-1:0]];
      rd_y_ff    <= mem_y[idx_ff[IdxBits-1:0]];
      rd_type_ff <= mem_type[idx_ff[IdxBits-1:0]];
   end

   assign mul_op = sq_sel_ff ? dy_ff : dx_ff;
   assign mul_p  = mul_op * mul_op;

   function automatic logic [DiffBits-1:0] absdiff(logic [CoordBits-1:0] a,
                                                   logic [CoordBits-1:0] b);
      logic signed [DiffBits-1:0] d;
      begin
         d = DiffBits'(signed'(a)) - DiffBits'(signed'(b));
         absdiff = d[DiffBits-1] ? DiffBits'(-d) : DiffBits'(d);
      end
   endfunction

   // candidate vs list entry i
   always_comb begin
      for (int i = 0; i < NearestCount; i++) begin
         if (dist_ff != bd_ff[i])
            beats[i] = dist_ff < bd_ff[i];
         else if (rd_y_ff != by_ff[i])
            beats[i] = signed'(rd_y_ff) < signed'(by_ff[i]);
         else
            beats[i] = rd_id_ff < bi_ff[i];
      end
   end

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      valid_in   = valid_ff;
      idx_in     = idx_ff;
      found_in   = found_ff;
      hit_in     = hit_ff;
      free_ok_in = free_ok_ff;
      free_in    = free_ff;
      sq_sel_in  = sq_sel_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      sq_in      = sq_ff;
      dist_in    = dist_ff;
      n_in       = n_ff;
      k_in       = k_ff;
      for (int i = 0; i < NearestCount; i++) begin
         bd_in[i] = bd_ff[i];
         by_in[i] = by_ff[i];
         bi_in[i] = bi_ff[i];
      end
      rsp_in   = rsp_ff;
      rsp_v_in = rsp_v_ff;
      if (rsp_v_ff && rsp.ready) rsp_v_in = 1'b0;
      we       = 1'b0;
      wa       = hit_ff;
      wr_id    = 1'b0;
      wd_id    = cur_ff.place_id;
      wd_x     = cur_ff.coord_x;
      wd_y     = cur_ff.coord_y;
      wd_type  = cur_ff.place_type;
      rt_start = 1'b0;
      req.ready = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // a response still waiting keeps the next request out
            req.ready = !rsp_v_ff || rsp.ready;
            if (req.valid && (!rsp_v_ff || rsp.ready)) begin
               cur_in     = req.payload;
               idx_in     = '0;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               n_in       = '0;
               case (req.payload.opcode)
                  OP_CLEAR: begin
                     valid_in = '0;
                     state_in = S_RSP;
                  end
                  OP_ADD, OP_REMOVE, OP_MOVE, OP_READ: state_in = S_SCAN_RD;
                  OP_QUERY: state_in = S_Q_RD;
                  default:  state_in = S_IDLE;
               endcase
               rsp_in = '{status: ST_OK, result_id: '0, result_x: '0,
                          result_y: '0, last_result: 1'b1};
            end
         end
         S_SCAN_RD: state_in = S_SCAN_CHK;
         S_SCAN_CHK: begin
            if (valid_ff[idx_ff[IdxBits-1:0]]) begin
               if (rd_id_ff == cur_ff.place_id && !found_ff) begin
                  found_in = 1'b1;
                  hit_in   = idx_ff[IdxBits-1:0];
               end
            end else if (!free_ok_ff) begin
               free_ok_in = 1'b1;
               free_in    = idx_ff[IdxBits-1:0];
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (IdxBits+1)'(TableDepth - 1)) state_in = S_FIN;
            else                                        state_in = S_SCAN_RD;
         end
         S_FIN: begin
            // hit_ff holds the matching slot; the rd data are not used here
            state_in = S_RSP;
            case (cur_ff.opcode)
               OP_ADD: begin
                  if (found_ff)        rsp_in.status = ST_PRESENT;
                  else if (!free_ok_ff) rsp_in.status = ST_FULL;
                  else begin
                     we = 1'b1; wr_id = 1'b1; wa = free_ff;
                     valid_in[free_ff] = 1'b1;
                  end
               end
               OP_REMOVE: begin
                  if (!found_ff) rsp_in.status = ST_ABSENT;
                  else valid_in[hit_ff] = 1'b0;
               end
               OP_MOVE: begin
                  if (!found_ff) rsp_in.status = ST_ABSENT;
                  else we = 1'b1;
               end
               OP_READ: begin
                  if (!found_ff) rsp_in.status = ST_ABSENT;
                  else begin
                     idx_in   = {1'b0, hit_ff};
                     state_in = S_EMIT;
                  end
               end
               default: state_in = S_RSP;
            endcase
         end
         S_EMIT: state_in = S_EMIT_ID;
         S_EMIT_ID: begin
            rsp_in.result_x = signed'(rd_x_ff);
            rsp_in.result_y = signed'(rd_y_ff);
            state_in = S_RSP;
         end
         S_Q_RD: state_in = S_Q_CHK;
         S_Q_CHK: begin
            if (valid_ff[idx_ff[IdxBits-1:0]] &&
                (cur_ff.place_type == AnyType || rd_type_ff == cur_ff.place_type)) begin
               dx_in     = absdiff(cur_ff.coord_x, rd_x_ff);
               dy_in     = absdiff(cur_ff.coord_y, rd_y_ff);
               sq_sel_in = 1'b0;
               state_in  = S_SQ;
            end else begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == (IdxBits+1)'(TableDepth - 1)) begin
                  k_in     = '0;
                  state_in = S_EMIT;
                  if (n_ff == '0) begin
                     rsp_in.status = ST_NO_MATCH;
                     state_in      = S_RSP;
                  end
               end else state_in = S_Q_RD;
            end
         end
         S_SQ: begin
            if (!sq_sel_ff) begin
               sq_in     = SqBits'(mul_p);
               sq_sel_in = 1'b1;
            end else begin
               sq_in    = sq_ff + SqBits'(mul_p);
               state_in = S_ROOT;
               // root starts next cycle with final sum
            end
         end
         S_ROOT: begin
            if (sq_sel_ff) begin
               rt_start  = 1'b1;
               sq_sel_in = 1'b0;
            end else if (rt_done) begin
               dist_in  = rt_root;
               state_in = S_INS;
            end
         end
         S_INS: begin
            for (int i = NearestCount - 1; i >= 0; i--) begin
               if (RankBits'(i) <= n_ff) begin
                  if (i > 0 && RankBits'(i) <= n_ff && beats[i-1]
                      && RankBits'(i - 1) < n_ff) begin
                     bd_in[i] = bd_ff[i-1]; by_in[i] = by_ff[i-1]; bi_in[i] = bi_ff[i-1];
                  end else if (RankBits'(i) == n_ff || beats[i]) begin
                     if (i == 0 || !(beats[i-1] && RankBits'(i - 1) < n_ff)) begin
                        bd_in[i] = dist_ff; by_in[i] = rd_y_ff; bi_in[i] = rd_id_ff;
                     end
                  end
               end
            end
            if (n_ff != RankBits'(NearestCount)) n_in = n_ff + 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (IdxBits+1)'(TableDepth - 1)) begin
               k_in     = '0;
               state_in = S_EMIT;
            end else state_in = S_Q_RD;
         end
         S_RSP: begin
            if (!rsp_v_ff || rsp.ready) begin
               rsp_v_in = 1'b1;
               if (cur_ff.opcode == OP_QUERY && rsp_ff.status == ST_OK) begin
                  k_in = k_ff + 1'b1;
                  if (k_ff + 1'b1 == n_ff) state_in = S_IDLE;
                  else                     state_in = S_EMIT;
               end else state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // query response fields are built just before sending
      if (state_ff == S_EMIT && cur_ff.opcode == OP_QUERY) begin
         state_in = S_EMIT;
         // wait until the previous result has left the output register
         if (!rsp_v_ff || rsp.ready) begin
            rsp_in.status      = ST_OK;
            rsp_in.result_x    = '0;
            rsp_in.result_y    = '0;
            rsp_in.result_id   = '0;
            for (int i = 0; i < NearestCount; i++)
               if (k_ff == RankBits'(i)) rsp_in.result_id = bi_ff[i];
            rsp_in.last_result = (k_ff + 1'b1 == n_ff);
            state_in = S_RSP;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      hit_ff    <= hit_in;
      free_ff   <= free_in;
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      sq_ff     <= sq_in;
      dist_ff   <= dist_in;
      rsp_ff    <= rsp_in;
      for (int i = 0; i < NearestCount; i++) begin
         bd_ff[i] <= bd_in[i];
         by_ff[i] <= by_in[i];
         bi_ff[i] <= bi_in[i];
      end
      if (reset) begin
         state_ff   <= S_IDLE;
         valid_ff   <= '0;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         free_ok_ff <= 1'b0;
         sq_sel_ff  <= 1'b0;
         n_ff       <= '0;
         k_ff       <= '0;
         rsp_v_ff   <= 1'b0;
      end else begin
         state_ff   <= state_in;
         valid_ff   <= valid_in;
         idx_ff     <= idx_in;
         found_ff   <= found_in;
         free_ok_ff <= free_ok_in;
         sq_sel_ff  <= sq_sel_in;
         n_ff       <= n_in;
         k_ff       <= k_in;
         rsp_v_ff   <= rsp_v_in;
      end
   end

   assign rsp.valid   = rsp_v_ff;
   assign rsp.payload = rsp_ff;

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req.ready) else $error("ready while busy");
   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= RankBits'(NearestCount)) else $error("rank count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && !rsp.ready |=> rsp_v_ff && $stable(rsp_ff))
      else $error("response dropped under stall");
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && cur_ff.opcode == OP_QUERY |-> k_ff < n_ff)
      else $error("emit past ranked list");
endmodule
